/* hw/rtl/vmalu_pkg.sv */
// ----------------------------------------------------------------------------
// vmalu_pkg
// Shared widths and opcode codes of the integer alu and branch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vmalu_pkg;

   localparam int DATA_W = 16;
   localparam int OP_W   = 5;
   // one extra bit so the divider also covers a length of 65536 and counter sums
   localparam int DIV_W  = DATA_W + 1;

   localparam logic [DATA_W-1:0] LEN_RESET = {DATA_W{1'b1}};

   localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 5'd1;
   localparam logic [OP_W-1:0] OP_MUL  = 5'd2;
   localparam logic [OP_W-1:0] OP_DIV  = 5'd3;
   localparam logic [OP_W-1:0] OP_MOD  = 5'd4;
   localparam logic [OP_W-1:0] OP_AND  = 5'd5;
   localparam logic [OP_W-1:0] OP_NAND = 5'd6;
   localparam logic [OP_W-1:0] OP_OR   = 5'd7;
   localparam logic [OP_W-1:0] OP_NOR  = 5'd8;
   localparam logic [OP_W-1:0] OP_XOR  = 5'd9;
   localparam logic [OP_W-1:0] OP_NOT  = 5'd10;
   localparam logic [OP_W-1:0] OP_JMP  = 5'd11;
   localparam logic [OP_W-1:0] OP_JZ   = 5'd12;
   localparam logic [OP_W-1:0] OP_JNZ  = 5'd13;
   localparam logic [OP_W-1:0] OP_JGT  = 5'd14;
   localparam logic [OP_W-1:0] OP_JLT  = 5'd15;
   localparam logic [OP_W-1:0] OP_JGE  = 5'd16;
   localparam logic [OP_W-1:0] OP_JLE  = 5'd17;

endpackage

`default_nettype wire

/* hw/rtl/vmalu_mul.sv */
// ----------------------------------------------------------------------------
// vmalu_mul
// Bit-serial shift-add multiplier, keeps the low DATA_W bits of the product.
// ----------------------------------------------------------------------------
`default_nettype none

module vmalu_mul
   import vmalu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] mcand,
   input  wire logic [DATA_W-1:0] mplier,
   output logic                   busy,
   output logic                   done,
   output logic [DATA_W-1:0]      product
);

   localparam int CNT_W = $clog2(DATA_W);

   logic [DATA_W-1:0] mcand_ff, mcand_in;
   logic [DATA_W-1:0] mplier_ff, mplier_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = mcand;
         mplier_in = mplier;
         acc_in    = '0;
         cnt_in    = CNT_W'(DATA_W - 1);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         // low bits of a signed product equal those of the unsigned one
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mcand_in  = {mcand_ff[DATA_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[DATA_W-1:1]};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

/* hw/rtl/vmalu_div.sv */
// ----------------------------------------------------------------------------
// vmalu_div
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vmalu_div
   import vmalu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DIV_W-1:0] divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIV_W-1:0]      quotient,
   output logic [DIV_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so it fits DIV_W bits
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* hw/rtl/vm_integer_alu_and_branch_unit.sv */
// ----------------------------------------------------------------------------
// vm_integer_alu_and_branch_unit
// Integer alu and branch unit of a small bytecode machine.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one instruction per transaction (opcode, two signed
//   operands); rsp_* returns one transaction per instruction with the result
//   and the program counter after it. Both use valid/stall; the unit raises
//   req_stall while an instruction is in progress.
//   csr_* writes program_length (ready is always high); write it only when
//   the unit is idle. A length of zero acts as 65536.
// Sequencing (acceptance to acceptance):
//   add, sub, logic ops, untaken jumps and zero divisors: result registered on acceptance
//   mul: runs the 16 steps of the bit-serial multiplier
//   div, mod and taken jumps: run the 17 steps of the shared
//   restoring divider (a taken jump reduces pc + distance modulo the length)
//   rsp_valid rises once the output register loads the finished result.
// Reset clears the program counter, sets the length to 65535 and empties the
// output register. A stalled response holds; one finished result may wait in
// the unit behind it, after which req_stall stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module vm_integer_alu_and_branch_unit
   import vmalu_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OP_W-1:0]          req_type,
   input  wire logic signed [DATA_W-1:0] req_operand_a,
   input  wire logic signed [DATA_W-1:0] req_operand_b,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [DATA_W-1:0]             rsp_result_value,
   output logic [DATA_W-1:0]             rsp_next_counter,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [DATA_W-1:0]        csr_program_length
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_WRAP = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [DATA_W-1:0] pc_ff, pc_in;
   logic [DATA_W-1:0] len_ff;
   logic [DATA_W-1:0] res_ff, res_in;
   logic              is_mod_ff, is_mod_in;
   logic              neg_q_ff, neg_q_in;
   logic              neg_r_ff, neg_r_in;
   logic              wrap_neg_ff, wrap_neg_in;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_res_ff;
   logic [DATA_W-1:0] rsp_cnt_ff;

   logic [DATA_W-1:0] a_u, b_u;
   logic              a_nz, b_nz, take;
   logic [DIV_W-1:0]  a_ext, b_ext, abs_a, abs_b;
   logic [DIV_W:0]    sum, sum_mag;
   logic [DIV_W-1:0]  len_ext;
   logic [DIV_W-1:0]  q_signed, r_signed, wrapped;
   logic              accept, out_load;

   logic              mul_start, mul_busy, mul_done;
   logic [DATA_W-1:0] mul_prod;
   logic              div_start, div_busy, div_done;
   logic [DIV_W-1:0]  div_dividend, div_divisor, div_quo, div_rem;

   vmalu_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (a_u),
      .mplier  (b_u),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_prod)
   );

   vmalu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign accept   = req_valid && !req_stall;
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      a_u     = req_operand_a;
      b_u     = req_operand_b;
      a_nz    = |a_u;
      b_nz    = |b_u;
      a_ext   = {a_u[DATA_W-1], a_u};
      b_ext   = {b_u[DATA_W-1], b_u};
      abs_a   = a_u[DATA_W-1] ? -a_ext : a_ext;
      abs_b   = b_u[DATA_W-1] ? -b_ext : b_ext;
      // pc + distance spans -32768 .. 98302
      sum     = {2'b00, pc_ff} + {{2{a_u[DATA_W-1]}}, a_u};
      sum_mag = sum[DIV_W] ? -sum : sum;
      len_ext = (len_ff == '0) ? {1'b1, {DATA_W{1'b0}}} : {1'b0, len_ff};

      q_signed = neg_q_ff ? -div_quo : div_quo;
      r_signed = neg_r_ff ? -div_rem : div_rem;
      wrapped  = (wrap_neg_ff && (div_rem != '0)) ? len_ext - div_rem : div_rem;

      case (req_type)
         OP_JMP:  take = 1'b1;
         OP_JZ:   take = !b_nz;
         OP_JNZ:  take = b_nz;
         OP_JGT:  take = !b_u[DATA_W-1] && b_nz;
         OP_JLT:  take = b_u[DATA_W-1];
         OP_JGE:  take = !b_u[DATA_W-1];
         OP_JLE:  take = b_u[DATA_W-1] || !b_nz;
         default: take = 1'b0;
      endcase

      div_dividend = (req_type inside {[OP_JMP:OP_JLE]}) ? sum_mag[DIV_W-1:0] : abs_a;
      div_divisor  = (req_type inside {[OP_JMP:OP_JLE]}) ? len_ext : abs_b;
   end

   always_comb begin
      state_in    = state_ff;
      pc_in       = pc_ff;
      res_in      = res_ff;
      is_mod_in   = is_mod_ff;
      neg_q_in    = neg_q_ff;
      neg_r_in    = neg_r_ff;
      wrap_neg_in = wrap_neg_ff;
      mul_start   = 1'b0;
      div_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in    = ST_DONE;
               res_in      = '0;
               is_mod_in   = (req_type == OP_MOD);
               neg_q_in    = a_u[DATA_W-1] ^ b_u[DATA_W-1];
               neg_r_in    = a_u[DATA_W-1];
               wrap_neg_in = sum[DIV_W];
               case (req_type)
                  OP_ADD:  res_in = a_u + b_u;
                  OP_SUB:  res_in = a_u - b_u;
                  OP_MUL: begin
                     mul_start = 1'b1;
                     state_in  = ST_MUL;
                  end
                  OP_DIV, OP_MOD: begin
                     if (b_nz) begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  OP_AND:  res_in = DATA_W'(a_nz && b_nz);
                  OP_NAND: res_in = DATA_W'(!(a_nz && b_nz));
                  OP_OR:   res_in = DATA_W'(a_nz || b_nz);
                  OP_NOR:  res_in = DATA_W'(!(a_nz || b_nz));
                  OP_XOR:  res_in = DATA_W'(a_nz ^ b_nz);
                  OP_NOT:  res_in = DATA_W'(!a_nz);
                  default: begin
                     if (take) begin
                        div_start = 1'b1;
                        state_in  = ST_WRAP;
                     end
                  end
               endcase
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               res_in   = mul_prod;
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = is_mod_ff ? r_signed[DATA_W-1:0] : q_signed[DATA_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_WRAP: begin
            if (div_done) begin
               res_in   = DATA_W'(1);
               pc_in    = wrapped[DATA_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         len_ff       <= LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (csr_valid && csr_ready) begin
            len_ff <= csr_program_length;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      res_ff      <= res_in;
      is_mod_ff   <= is_mod_in;
      neg_q_ff    <= neg_q_in;
      neg_r_ff    <= neg_r_in;
      wrap_neg_ff <= wrap_neg_in;
      if (out_load) begin
         rsp_res_ff <= res_ff;
         rsp_cnt_ff <= pc_ff;
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_res_ff;
   assign rsp_next_counter = rsp_cnt_ff;

   // new transaction only when both serial engines are free
   assert property (@(posedge clock) disable iff (reset)
      accept |-> (!mul_busy && !div_busy))
      else $error("transaction accepted while a serial engine is busy");

   assert property (@(posedge clock) disable iff (reset)
      !(mul_busy && div_busy))
      else $error("multiplier and divider busy together");

   // a taken jump leaves the counter inside the program
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRAP && div_done) |=> ({1'b0, pc_ff} < len_ext))
      else $error("wrapped counter not below program length");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_cnt_ff))
      else $error("stalled response counter changed");

endmodule

`default_nettype wire

/* tb/vmalu_result_checker.sv */
// ----------------------------------------------------------------------------
// vmalu_result_checker
// Predicts and checks every response of the integer alu and branch unit.
// Watches the request, response and length-write transactions. It keeps its
// own program counter and program length, works out the outcome of each
// accepted instruction, and compares each response field by field with the
// oldest outcome still waiting.
// ----------------------------------------------------------------------------
module vmalu_result_checker
   import vmalu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [OP_W-1:0]          req_type,
   input  logic signed [DATA_W-1:0] req_operand_a,
   input  logic signed [DATA_W-1:0] req_operand_b,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [DATA_W-1:0]        rsp_result_value,
   input  logic [DATA_W-1:0]        rsp_next_counter,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [DATA_W-1:0]        csr_program_length,
   output int                       mismatches,
   output int                       outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] counter;
   } outcome_type;

   logic [DATA_W-1:0] model_pc;
   logic [DATA_W-1:0] model_len;
   outcome_type       pending_outcomes[$];

   initial mismatches = 0;
   initial outstanding = 0;

   task automatic report_mismatch(input string what);
      $display("%0t ns: check failed: %s", $time, what);
      mismatches++;
   endtask

   // advances model_pc on a taken jump
   function automatic outcome_type execute_instr(input logic [OP_W-1:0]          op,
                                                 input logic signed [DATA_W-1:0] a_in,
                                                 input logic signed [DATA_W-1:0] b_in);
      int          a;
      int          b;
      int          res;
      int          span;
      int          sum;
      bit          is_jump;
      bit          taken;
      outcome_type pred;
      a       = a_in;
      b       = b_in;
      res     = 0;
      taken   = 1'b0;
      is_jump = op inside {[OP_JMP:OP_JLE]};
      case (op)
         OP_ADD:  res = a + b;
         OP_SUB:  res = a - b;
         OP_MUL:  res = a * b;
         OP_DIV:  res = (b == 0) ? 0 : a / b;
         OP_MOD:  res = (b == 0) ? 0 : a % b;
         OP_AND:  res = int'((a != 0) && (b != 0));
         OP_NAND: res = int'(!((a != 0) && (b != 0)));
         OP_OR:   res = int'((a != 0) || (b != 0));
         OP_NOR:  res = int'(!((a != 0) || (b != 0)));
         OP_XOR:  res = int'((a != 0) != (b != 0));
         OP_NOT:  res = int'(a == 0);
         OP_JMP:  taken = 1'b1;
         OP_JZ:   taken = (b == 0);
         OP_JNZ:  taken = (b != 0);
         OP_JGT:  taken = (b > 0);
         OP_JLT:  taken = (b < 0);
         OP_JGE:  taken = (b >= 0);
         OP_JLE:  taken = (b <= 0);
         default: res = 0;
      endcase
      if (is_jump) begin
         if (taken) begin
            // a zero length means the full 16-bit range
            span = (model_len == '0) ? (1 << DATA_W) : int'(model_len);
            sum  = (int'(model_pc) + a) % span;
            if (sum < 0) begin
               sum += span;
            end
            model_pc = sum[DATA_W-1:0];
         end
         res = int'(taken);
      end
      pred.op      = op;
      pred.value   = res[DATA_W-1:0];
      pred.counter = model_pc;
      return pred;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         model_pc  = '0;
         model_len = LEN_RESET;
         pending_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            model_len = csr_program_length;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch($sformatf("response value %h counter %h with nothing outstanding",
                                         rsp_result_value, rsp_next_counter));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_result_value !== want.value) begin
                  report_mismatch($sformatf("op %0d result_value got %h want %h",
                                            want.op, rsp_result_value, want.value));
               end
               if (rsp_next_counter !== want.counter) begin
                  report_mismatch($sformatf("op %0d next_counter got %h want %h",
                                            want.op, rsp_next_counter, want.counter));
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_outcomes.push_back(execute_instr(req_type, req_operand_a, req_operand_b));
         end
      end
      outstanding <= pending_outcomes.size();
   end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the integer alu and branch unit.
// Runs directed corner instructions, then random instructions under a series
// of program lengths, with bursty requests and a randomly stalling receiver;
// vmalu_result_checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vmalu_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 4;
   localparam int LONG_HOLD     = 300;
   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 40;
   localparam int PHASE_ITEMS   = 150;

   localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_JLE + 1'b1;
   localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

   logic                     clock              = 1'b0;
   logic                     reset              = 1'b1;
   logic                     req_valid          = 1'b0;
   logic [OP_W-1:0]          req_type           = OP_ADD;
   logic signed [DATA_W-1:0] req_operand_a      = '0;
   logic signed [DATA_W-1:0] req_operand_b      = '0;
   logic                     rsp_stall          = 1'b0;
   logic                     csr_valid          = 1'b0;
   logic [DATA_W-1:0]        csr_program_length = LEN_RESET;

   logic                     req_stall;
   logic                     rsp_valid;
   logic [DATA_W-1:0]        rsp_result_value;
   logic [DATA_W-1:0]        rsp_next_counter;
   logic                     csr_ready;

   int mismatches;
   int outstanding;
   int quiet_cycles  = 0;
   int burst_left    = 0;
   bit hold_request  = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   vm_integer_alu_and_branch_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_value   (rsp_result_value),
      .rsp_next_counter   (rsp_next_counter),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_program_length (csr_program_length)
   );

   vmalu_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_value   (rsp_result_value),
      .rsp_next_counter   (rsp_next_counter),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_program_length (csr_program_length),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   // offers one instruction, waits for the edge that accepts it, then may idle for a random gap
   task automatic send_instr(input logic [OP_W-1:0] op, input int a, input int b);
      int gap;
      req_type      <= op;
      req_operand_a <= a[DATA_W-1:0];
      req_operand_b <= b[DATA_W-1:0];
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (burst_left <= 0) begin
         case ($urandom_range(3, 0))
            0:       gap = 0;
            1:       gap = $urandom_range(2, 1);
            2:       gap = $urandom_range(8, 3);
            default: gap = $urandom_range(30, 9);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 30)
                                                   : $urandom_range(24, 1);
      end
   endtask

   // stop offering and wait for every outstanding transaction to return
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [DATA_W-1:0] len);
      drain();
      csr_program_length <= len;
      csr_valid          <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_operand();
      case ($urandom_range(9, 0))
         0:       return 0;
         1:       return 1;
         2:       return -1;
         3:       return 32767;
         4:       return -32768;
         5, 6:    return int'($urandom_range(24, 0)) - 12;
         default: return int'($urandom_range(16'hFFFF, 0)) - 32768;
      endcase
   endfunction

   task automatic send_random(input int span);
      logic [OP_W-1:0] op;
      int              a;
      int              b;
      if ($urandom_range(19, 0) == 0) begin
         op = OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
      end else begin
         op = OP_W'($urandom_range(OP_JLE, OP_ADD));
      end
      a = pick_operand();
      b = pick_operand();
      // distances around the program length hit both wrap directions
      if (op >= OP_JMP && op <= OP_JLE && $urandom_range(1, 0) == 1) begin
         a = int'($urandom_range(2 * span, 0)) - span;
      end
      send_instr(op, a, b);
   endtask

   initial begin : rsp_backpressure
      int stretch;
      int stall_pct;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stretch = $urandom_range(40, 1);
            case ($urandom_range(3, 0))
               0:       stall_pct = 0;
               1:       stall_pct = 25;
               2:       stall_pct = 60;
               default: stall_pct = 90;
            endcase
            repeat (stretch) begin
               rsp_stall <= ($urandom_range(99, 0) < stall_pct);
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [DATA_W-1:0] len_plan [12];
      int                span;
      len_plan = '{16'd1, 16'd2, 16'd0, 16'd65535, 16'd7, 16'd32768,
                   16'd100, 16'd3, 16'd65534, 16'd0, 16'd0, 16'd0};
      len_plan[9]  = DATA_W'($urandom_range(16'hFFFF, 1));
      len_plan[10] = DATA_W'($urandom_range(64, 1));
      len_plan[11] = DATA_W'($urandom_range(16'hFFFF, 0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // corners under the length left by reset
      send_instr(OP_ADD, 32767, 1);
      send_instr(OP_SUB, -32768, 1);
      send_instr(OP_MUL, -32768, -32768);
      send_instr(OP_MUL, 32767, -32767);
      send_instr(OP_DIV, -32768, -1);
      send_instr(OP_MOD, -32768, -1);
      send_instr(OP_DIV, 1234, 0);
      send_instr(OP_MOD, -1234, 0);
      send_instr(OP_DIV, -7, 2);
      send_instr(OP_MOD, -7, 2);
      send_instr(OP_MOD, 7, -2);
      send_instr(OP_AND, -32768, 1);
      send_instr(OP_NAND, 5, 0);
      send_instr(OP_OR, 0, 0);
      send_instr(OP_NOR, 0, 0);
      send_instr(OP_XOR, 32767, 0);
      send_instr(OP_NOT, 0, -1);
      send_instr(OP_FIRST_UNUSED, 3, 4);
      send_instr(OP_LAST_UNUSED, -1, -1);
      send_instr(OP_JMP, -1, 0);
      send_instr(OP_JZ, 32767, 0);
      send_instr(OP_JNZ, 5, 0);
      send_instr(OP_JGT, -32768, 32767);
      send_instr(OP_JLT, 3, -32768);
      send_instr(OP_JGE, 1, 0);
      send_instr(OP_JLE, 9, 1);

      // full 16-bit wrap, then a counter left beyond a shorter length
      write_length('0);
      send_instr(OP_JMP, 32767, 0);
      send_instr(OP_JMP, 32767, 0);
      write_length(16'd7);
      send_instr(OP_ADD, 2, 3);
      send_instr(OP_JZ, 3, 0);

      foreach (len_plan[p]) begin
         write_length(len_plan[p]);
         span = (len_plan[p] == '0) ? (1 << DATA_W) : int'(len_plan[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == 40) begin
               hold_request = 1'b1;
            end
            if (p == 5 && i == 75) begin
               drain();
            end
            send_random(span);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
